/* rtl/sem_pkg.sv */
// Shared types and constants for the Sobel edge magnitude block.
// Holds the item structs, controller states and ctrl/datapath command and status.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sem_pkg;

    localparam int unsigned PIX_W   = 8;
    localparam int unsigned EDGE_W  = 11;
    localparam int unsigned CFGW_W  = 11;
    localparam int unsigned CFGH_W  = 16;
    localparam int unsigned CFGD_W  = 16;
    localparam int unsigned ABS_W   = 10;
    localparam int unsigned SQ_W    = 20;
    localparam int unsigned RAD_W   = 22;
    localparam int unsigned REM_W   = 14;
    localparam int unsigned STEP_W  = 4;
    localparam logic [STEP_W-1:0] ROOT_STEPS_M1 = 4'd10;

    localparam logic [CFGW_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFGH_W-1:0] HEIGHT_RESET = 16'd480;
    localparam logic [EDGE_W-1:0] EDGE_MAX     = 11'd1442;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_DRAIN = 1'b1
    } t_req;

    typedef struct packed {
        logic              req_type;
        logic [PIX_W-1:0]  pixel_value;
    } t_in_item;

    typedef struct packed {
        logic [EDGE_W-1:0] edge_value;
        logic              end_of_frame;
    } t_out_item;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_WIN  = 7'b0000010,
        S_GRAD = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_SUM  = 7'b0010000,
        S_ROOT = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    typedef struct packed {
        logic pix_take;
        logic drain_take;
        logic win;
        logic grad;
        logic mul;
        logic sum;
        logic root;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic drain_pend;
        logic emit;
        logic mag;
        logic root_last;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

/* rtl/sem_ctrl.sv */
// Controller state machine for the Sobel edge magnitude block.
// Sequences one item at a time through the datapath; depends on sem_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sem_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_in_req,
    output logic                o_in_stall,
    input  wire sem_pkg::t_sts  i_sts,
    output sem_pkg::t_cmd       o_cmd
);
    import sem_pkg::*;

    t_state r_state, n_state;
    logic   w_acc;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_acc      = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_in_req == REQ_DRAIN) begin
                        if (i_sts.drain_pend) begin
                            o_cmd.drain_take = 1'b1;
                            n_state = S_DONE;
                        end
                    end else if (!i_sts.drain_pend) begin
                        o_cmd.pix_take = 1'b1;
                        n_state = S_WIN;
                    end
                end
            end
            S_WIN: begin
                o_cmd.win = 1'b1;
                if (!i_sts.emit) n_state = S_IDLE;
                else if (!i_sts.mag) n_state = S_DONE;
                else n_state = S_GRAD;
            end
            S_GRAD: begin
                o_cmd.grad = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root = 1'b1;
                if (i_sts.root_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

/* rtl/sem_dp.sv */
// Datapath for the Sobel edge magnitude block: line stores, window, counters,
// gradient, squaring, bit-serial square root and output register. Uses sem_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sem_dp #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_index,
    input  wire logic [sem_pkg::CFGD_W-1:0]    i_cfg_data,
    input  wire sem_pkg::t_in_item             i_in_data,
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output sem_pkg::t_out_item                 o_out_data,
    input  wire sem_pkg::t_cmd                 i_cmd,
    output sem_pkg::t_sts                      o_sts
);
    import sem_pkg::*;

    localparam int unsigned AW = $clog2(MAX_WIDTH);
    localparam int unsigned WW = $clog2(MAX_WIDTH + 2);

    logic [CFGW_W-1:0] r_width;
    logic [CFGH_W-1:0] r_height;
    logic [AW-1:0]     r_col, r_x;
    logic [CFGH_W-1:0] r_row, r_y;
    logic [WW-1:0]     r_drain;
    logic [PIX_W-1:0]  r_pix, r_above, r_mid;
    logic [PIX_W-1:0]  r_upper [0:MAX_WIDTH-1];
    logic [PIX_W-1:0]  r_lower [0:MAX_WIDTH-1];
    logic [PIX_W-1:0]  r_win [0:2][0:2];
    logic [ABS_W-1:0]  r_ax, r_ay;
    logic [SQ_W-1:0]   r_sqx, r_sqy;
    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [EDGE_W-1:0] r_root;
    logic [STEP_W-1:0] r_step;
    logic [EDGE_W-1:0] r_res;
    logic              r_eof;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [WW-1:0]     w_weff;
    logic [CFGH_W-1:0] w_heff;
    logic [AW-1:0]     w_addr;
    logic [PIX_W+1:0]  w_xp, w_xn, w_yp, w_yn;
    logic [REM_W-1:0]  w_rsh, w_trial;
    logic              w_ge;
    logic [EDGE_W-1:0] n_root;

    always_comb begin
        if (r_width == '0) w_weff = WW'(1);
        else if (32'(r_width) > 32'(MAX_WIDTH)) w_weff = WW'(MAX_WIDTH);
        else w_weff = WW'(r_width);
        w_heff = (r_height == '0) ? CFGH_W'(1) : r_height;
        w_addr = (WW'(r_col) >= w_weff) ? '0 : r_col;
    end

    assign o_sts.drain_pend = (r_drain != '0);
    assign o_sts.emit       = (r_y >= CFGH_W'(2)) || (r_y == CFGH_W'(1) && r_x != '0);
    assign o_sts.mag        = (r_y >= CFGH_W'(2)) && (r_x >= AW'(2));
    assign o_sts.root_last  = (r_step == '0);
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_col    <= '0;
            r_row    <= '0;
            r_drain  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_WIDTH) r_width <= i_cfg_data[CFGW_W-1:0];
            else r_height <= i_cfg_data;
            r_col   <= '0;
            r_row   <= '0;
            r_drain <= '0;
        end else if (i_cmd.drain_take) begin
            r_drain <= r_drain - WW'(1);
        end else if (i_cmd.win) begin
            if (WW'(r_x) + WW'(1) >= w_weff) begin
                r_col <= '0;
                if (32'(r_y) + 32'd1 >= 32'(w_heff)) begin
                    r_row   <= '0;
                    r_drain <= (w_heff == CFGH_W'(1)) ? w_weff : w_weff + WW'(1);
                end else begin
                    r_row <= r_y + CFGH_W'(1);
                end
            end else begin
                r_col <= r_x + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_take) begin
            r_above <= r_upper[w_addr];
            r_mid   <= r_lower[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.win) begin
            r_upper[r_x] <= r_mid;
            r_lower[r_x] <= r_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_take) begin
            r_x   <= w_addr;
            r_y   <= r_row;
            r_pix <= i_in_data.pixel_value;
        end
        if (i_cmd.win) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= r_above;
            r_win[1][2] <= r_mid;
            r_win[2][2] <= r_pix;
        end
    end

    always_comb begin
        w_xp = {2'b0, r_win[0][2]} + {1'b0, r_win[1][2], 1'b0} + {2'b0, r_win[2][2]};
        w_xn = {2'b0, r_win[0][0]} + {1'b0, r_win[1][0], 1'b0} + {2'b0, r_win[2][0]};
        w_yp = {2'b0, r_win[2][0]} + {1'b0, r_win[2][1], 1'b0} + {2'b0, r_win[2][2]};
        w_yn = {2'b0, r_win[0][0]} + {1'b0, r_win[0][1], 1'b0} + {2'b0, r_win[0][2]};
        w_rsh   = {r_rem[REM_W-3:0], r_rad[RAD_W-1:RAD_W-2]};
        w_trial = {1'b0, r_root, 2'b01};
        w_ge    = (w_rsh >= w_trial);
        n_root  = {r_root[EDGE_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.grad) begin
            r_ax <= (w_xp >= w_xn) ? w_xp - w_xn : w_xn - w_xp;
            r_ay <= (w_yp >= w_yn) ? w_yp - w_yn : w_yn - w_yp;
        end
        if (i_cmd.mul) begin
            r_sqx <= r_ax * r_ax;
            r_sqy <= r_ay * r_ay;
        end
        if (i_cmd.sum) begin
            r_rad  <= RAD_W'(r_sqx) + RAD_W'(r_sqy);
            r_rem  <= '0;
            r_root <= '0;
            r_step <= ROOT_STEPS_M1;
        end
        if (i_cmd.root) begin
            r_rad  <= r_rad << 2;
            r_rem  <= w_ge ? w_rsh - w_trial : w_rsh;
            r_root <= n_root;
            r_step <= r_step - STEP_W'(1);
            r_res  <= n_root;
        end
        if (i_cmd.drain_take) begin
            r_res <= '0;
            r_eof <= (r_drain == WW'(1));
        end
        if (i_cmd.win) begin
            r_res <= '0;
            r_eof <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out.edge_value   <= r_res;
            r_out.end_of_frame <= r_eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

/* rtl/sobel_edge_magnitude.sv */
// Usage: streaming 3x3 Sobel gradient magnitude over a raster frame.
// Input channel i_in_valid/o_in_stall carries one item: a pixel or a drain request.
// Output channel o_out_valid/i_out_stall carries edge_value and end_of_frame.
// Configuration: i_cfg_we writes image_width (index 0) or image_height (index 1)
// and restarts the frame; write only while the block is idle.
// A pixel item gives no result, a border zero or a magnitude; a magnitude passes
// through the gradient, squaring, sum and square root states, and the square root is
// resolved one result bit per cycle in the datapath.
// A drain item with no result pending gives nothing; a pixel item sent while
// drain results are pending is dropped.
// Results lag their pixel by width+1 positions;
// after the last pixel, drain items release the remaining zero results and the
// last one carries end_of_frame. A new item is taken while the previous result
// still waits in the output register. When the receiver stalls, the result
// holds and the next item waits in the final state until the register frees.
// Synchronous reset: sizes return to 640x480, the frame restarts, both channels
// go idle. Line store contents are not cleared; no clearing pass is needed.
// Depends on sem_pkg, sem_ctrl and sem_dp.
`timescale 1ns / 1ps
`default_nettype none
module sobel_edge_magnitude #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_index,
    input  wire logic [sem_pkg::CFGD_W-1:0]  i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire sem_pkg::t_in_item           i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output sem_pkg::t_out_item               o_out_data
);
    import sem_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    sem_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_req   (i_in_data.req_type),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sem_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

`ifndef SYNTHESIS
    a_cfg_clears_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !w_sts.drain_pend)
        else $error("drain still pending after register write");
    a_eof_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.end_of_frame) |-> (o_out_data.edge_value == '0))
        else $error("end of frame with nonzero edge value");
    a_edge_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.edge_value <= EDGE_MAX))
        else $error("edge value out of range");
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.out_load && o_out_valid) |-> !i_out_stall)
        else $error("result loaded over a stalled result");
`endif

endmodule
`default_nettype wire

/* verif/sobel_edge_magnitude_test.sv */
// Self-checking bench for sobel_edge_magnitude: directed frames, then random frames.
// Predicts each result with a Sobel line-store model and compares it in order.
// Depends on sem_pkg and the sobel_edge_magnitude RTL.
`timescale 1ns / 1ps
module sobel_edge_magnitude_test;
    import sem_pkg::*;

    localparam int MAXW = 1024;
    localparam longint CYCLE_LIMIT = 3000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_index = 1'b0;
    logic [CFGD_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in_item i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out_item o_out_data;

    sobel_edge_magnitude i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    int unsigned frame_w, frame_h;
    logic [7:0] upper_row [MAXW];
    logic [7:0] lower_row [MAXW];
    logic [7:0] win [3][3];
    int unsigned col_pos, row_pos, drains_left;

    t_out_item edge_queue [$];
    int errors = 0;
    longint cycles = 0;
    bit quiet_out = 1'b0;
    bit hold_long = 1'b0;
    bit hold_go = 1'b0;

    function automatic int unsigned isqrt(int unsigned v);
        int unsigned r;
        r = 0;
        while ((r + 1) * (r + 1) <= v) r++;
        return r;
    endfunction

    function automatic int unsigned sobel_mag();
        int gx, gy;
        gx = (win[0][2] + 2 * win[1][2] + win[2][2]) - (win[0][0] + 2 * win[1][0] + win[2][0]);
        gy = (win[2][0] + 2 * win[2][1] + win[2][2]) - (win[0][0] + 2 * win[0][1] + win[0][2]);
        return isqrt(gx * gx + gy * gy);
    endfunction

    task automatic restart_frame();
        col_pos = 0;
        row_pos = 0;
        drains_left = 0;
    endtask

    task automatic set_reg(t_reg_idx idx, logic [CFGD_W-1:0] val);
        if (idx == REG_WIDTH) frame_w = 32'(val[CFGW_W-1:0]);
        else frame_h = 32'(val);
        restart_frame();
    endtask

    // returns 1 when a result is produced
    function automatic bit predict_item(t_in_item it, output t_out_item res);
        int unsigned w, h, x, y, mag, total;
        bit emit;
        w = (frame_w < 1) ? 1 : (frame_w > MAXW ? MAXW : frame_w);
        h = (frame_h < 1) ? 1 : frame_h;
        res = '0;
        mag = 0;
        if (it.req_type == REQ_DRAIN) begin
            if (drains_left == 0) return 0;
            drains_left--;
            res.end_of_frame = (drains_left == 0);
            return 1;
        end
        if (drains_left != 0) return 0;
        x = col_pos;
        y = row_pos;
        if (x >= w) x = 0;
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = upper_row[x];
        win[1][2] = lower_row[x];
        win[2][2] = it.pixel_value;
        upper_row[x] = lower_row[x];
        lower_row[x] = it.pixel_value;
        emit = (y >= 2) || (y == 1 && x >= 1);
        if (emit && x >= 2 && y >= 2) mag = sobel_mag();
        if (x + 1 >= w) begin
            col_pos = 0;
            if (y + 1 >= h) begin
                total = w * h;
                row_pos = 0;
                drains_left = (w + 1 < total) ? w + 1 : total;
            end else begin
                row_pos = y + 1;
            end
        end else begin
            col_pos = x + 1;
            row_pos = y;
        end
        res.edge_value = mag[EDGE_W-1:0];
        return emit;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // output side: random stall, checking
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (edge_queue.size() == 0) begin
                report_mismatch("unexpected item", o_out_data.edge_value, -1);
            end else begin
                if (o_out_data.edge_value !== edge_queue[0].edge_value)
                    report_mismatch("edge_value", o_out_data.edge_value,
                        edge_queue[0].edge_value);
                if (o_out_data.end_of_frame !== edge_queue[0].end_of_frame)
                    report_mismatch("end_of_frame", o_out_data.end_of_frame,
                        edge_queue[0].end_of_frame);
                void'(edge_queue.pop_front());
            end
        end
        i_out_stall <= hold_long || (!quiet_out && $urandom_range(99) < 12);
    end

    initial begin
        int cnt;
        cnt = 0;
        wait (hold_go);
        hold_long = 1'b1;
        while (cnt < 400) begin
            @(posedge i_clk);
            cnt++;
        end
        hold_long = 1'b0;
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    bit quiet_in = 1'b0;

    task automatic send_item(t_in_item it, bit has_want, t_out_item want);
        t_out_item res;
        while (!quiet_in && $urandom_range(99) < 12) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        if (predict_item(it, res)) begin
            if (has_want && res != want)
                report_mismatch("directed table", res.edge_value, want.edge_value);
            edge_queue.push_back(res);
        end
    endtask

    task automatic write_reg(t_reg_idx idx, int unsigned val);
        i_in_valid <= 1'b0;
        while (edge_queue.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[CFGD_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        set_reg(idx, val[CFGD_W-1:0]);
    endtask

    task automatic pixel(logic [7:0] p);
        t_in_item it;
        it.req_type = REQ_PIXEL;
        it.pixel_value = p;
        send_item(it, 1'b0, '0);
    endtask

    task automatic drain();
        t_in_item it;
        it.req_type = REQ_DRAIN;
        it.pixel_value = 8'($urandom_range(255));
        send_item(it, 1'b0, '0);
    endtask

    typedef struct {
        t_in_item it;
        bit has_want;
        t_out_item want;
    } t_row;

    t_row directed [$];
    int unsigned sent;

    initial begin
        t_out_item none;
        int unsigned w, h;
        none = '0;
        frame_w = 32'(WIDTH_RESET);
        frame_h = 32'(HEIGHT_RESET);
        restart_frame();
        for (int i = 0; i < MAXW; i++) begin
            upper_row[i] = '0;
            lower_row[i] = '0;
        end
        for (int r = 0; r < 3; r++) for (int c = 0; c < 3; c++) win[r][c] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // drain with nothing pending gives nothing
        directed.push_back('{'{REQ_DRAIN, 8'h00}, 1'b0, none});
        // 3x3 frame with a hard vertical edge
        write_reg(REG_WIDTH, 3);
        write_reg(REG_HEIGHT, 3);
        for (int i = 0; i < 9; i++)
            directed.push_back('{'{REQ_PIXEL, (i % 3 == 0) ? 8'hff : 8'h00},
                1'b0, none});
        directed.push_back('{'{REQ_PIXEL, 8'h55}, 1'b0, none}); // ignored while draining
        for (int i = 0; i < 4; i++)
            directed.push_back('{'{REQ_DRAIN, 8'hff}, 1'b1,
                '{11'd0, (i == 3)}});
        directed.push_back('{'{REQ_DRAIN, 8'h00}, 1'b0, none});
        foreach (directed[i]) send_item(directed[i].it, directed[i].has_want, directed[i].want);

        // corner magnitude: 255 in the three top-left corner pixels, zero elsewhere
        for (int i = 0; i < 9; i++) pixel((i == 0 || i == 1 || i == 3) ? 8'hff : 8'h00);
        repeat (4) drain();

        // tiny and out-of-range sizes
        write_reg(REG_WIDTH, 0);
        write_reg(REG_HEIGHT, 0);
        pixel(8'h12);
        drain();
        drain();
        write_reg(REG_WIDTH, 2047);
        write_reg(REG_HEIGHT, 2);
        for (int i = 0; i < MAXW + 2; i++) pixel(8'($urandom_range(255)));
        write_reg(REG_WIDTH, 5);
        write_reg(REG_HEIGHT, 65535);
        hold_go = 1'b1;
        for (int i = 0; i < 30; i++) pixel(8'($urandom_range(255)));
        write_reg(REG_HEIGHT, 4); // abandon frame midway

        // random frames, mostly small, with long quiet stretch partway
        sent = 0;
        while (sent < 110) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 8);
            h = $urandom_range(1, 5);
            write_reg(REG_WIDTH, w);
            write_reg(REG_HEIGHT, h);
            quiet_in = (sent > 30 && sent < 80);
            quiet_out = quiet_in;
            for (int i = 0; i < w * h; i++) begin
                if ($urandom_range(49) == 0) drain();
                pixel(($urandom_range(3) == 0) ? (($urandom_range(1) == 0) ? 8'h00 : 8'hff)
                    : 8'($urandom_range(255)));
                sent++;
            end
            if ($urandom_range(9) == 0) pixel(8'($urandom_range(255)));
            for (int i = 0; i < w + 1 + $urandom_range(2); i++) drain();
        end
        quiet_in = 1'b0;
        quiet_out = 1'b0;
        i_in_valid <= 1'b0;
        while (edge_queue.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/sem_pkg.sv
rtl/sem_ctrl.sv
rtl/sem_dp.sv
rtl/sobel_edge_magnitude.sv
verif/sobel_edge_magnitude_test.sv
